FILE: rtl/ifssd_pkg.sv
// ============================================================================
// ifssd_pkg
// Shared widths, register map, reset values and types of the interlace field
// SSD metric.
// ============================================================================
`default_nettype none

package ifssd_pkg;

    localparam int PIX_W     = 8;
    localparam int SQ_W      = 2 * PIX_W;
    localparam int LS_DW     = 2 * PIX_W;
    localparam int ACC_W     = 40;
    localparam int FIELD_W   = 39;
    localparam int GAMMA_W   = 24;
    localparam int INT_BITS  = 8;
    localparam int FRAC_BITS = 16;
    localparam int GCNT_W    = $clog2(GAMMA_W);

    localparam int CFG_W     = 13;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam int               MIN_FRAME_HEIGHT = 4;

    typedef struct packed {
        logic [ACC_W-1:0] frame;
        logic [ACC_W-1:0] even;
        logic [ACC_W-1:0] odd;
    } frame_sums_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MUL,
        G_CHECK,
        G_DIV,
        G_DONE
    } gamma_state_t;

endpackage

`default_nettype wire

FILE: rtl/ifssd_if.sv
// ============================================================================
// ifssd_if
// Valid/ready channels: one luma pixel per beat in, one frame result per
// beat out.
// ============================================================================
`default_nettype none

interface ifssd_pix_if import ifssd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ifssd_res_if import ifssd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACC_W-1:0]   frame_ssd;
    logic [FIELD_W-1:0] even_field_ssd;
    logic [FIELD_W-1:0] odd_field_ssd;
    logic [GAMMA_W-1:0] gamma_q16;
    logic               gamma_saturated;

    modport source (output valid, output frame_ssd, output even_field_ssd,
                    output odd_field_ssd, output gamma_q16, output gamma_saturated,
                    input ready);
    modport sink   (input valid, input frame_ssd, input even_field_ssd,
                    input odd_field_ssd, input gamma_q16, input gamma_saturated,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ifssd_line_store.sv
// ============================================================================
// ifssd_line_store
// Line memory holding the pixels one and two rows above each column, with a
// registered read and forwarding of a write to the same column.
// ============================================================================
`default_nettype none

module ifssd_line_store import ifssd_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [LS_DW-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [LS_DW-1:0] wr_data
);

    logic [LS_DW-1:0] mem [DEPTH];
    logic [LS_DW-1:0] q_reg;
    logic [LS_DW-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic             fwd_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // A read that meets a write of the same column in the same cycle sees the
    // old word in the array, so the new word is taken from a bypass register.
    assign fwd_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_next)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule

`default_nettype wire

FILE: rtl/ifssd_gamma.sv
// ============================================================================
// ifssd_gamma
// End-of-frame ratio unit: two multiplies, a range check and a restoring
// divider producing one quotient bit per cycle, followed by the result
// register.
// ============================================================================
`default_nettype none

module ifssd_gamma import ifssd_pkg::*; #(
    parameter int HW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire frame_sums_t   sums,
    input  wire logic [HW-2:0] half_m1,
    input  wire logic [HW-1:0] h_m1,
    output logic               busy,
    ifssd_res_if.source        res
);

    localparam int NUM_W = ACC_W + HW - 1;
    localparam int DEN_W = ACC_W + 1 + HW;
    localparam int REM_W = DEN_W + GAMMA_W;

    gamma_state_t state_reg, state_next;

    logic [ACC_W-1:0]   frame_reg;
    logic [ACC_W-1:0]   even_reg;
    logic [ACC_W-1:0]   odd_reg;
    logic [ACC_W:0]     fsum_reg;
    logic [HW-2:0]      half_reg;
    logic [HW-1:0]      hm1_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   dsh_reg;
    logic [GAMMA_W-1:0] quo_reg;
    logic               sat_reg;
    logic [GCNT_W-1:0]  cnt_reg;

    logic               out_valid_reg;
    logic [ACC_W-1:0]   out_frame_reg;
    logic [FIELD_W-1:0] out_even_reg;
    logic [FIELD_W-1:0] out_odd_reg;
    logic [GAMMA_W-1:0] out_gamma_reg;
    logic               out_sat_reg;

    logic               overflow;
    logic               take;
    logic               last_step;
    logic               load_out;

    // The quotient reaches 2^24 exactly when num >= den * 256.
    assign overflow  = (den_reg == '0)
                       || (REM_W'(num_reg) >= (REM_W'(den_reg) << INT_BITS));
    assign take      = rem_reg >= dsh_reg;
    assign last_step = cnt_reg == GCNT_W'(GAMMA_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE:  if (start) state_next = G_MUL;
            G_MUL:   state_next = G_CHECK;
            G_CHECK: state_next = overflow ? G_DONE : G_DIV;
            G_DIV:   if (last_step) state_next = G_DONE;
            G_DONE:  if (load_out) state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = state_reg != G_IDLE;
        load_out = (state_reg == G_DONE) && (!out_valid_reg || res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= G_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == G_CHECK)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == G_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    frame_reg <= sums.frame;
                    even_reg  <= sums.even;
                    odd_reg   <= sums.odd;
                    fsum_reg  <= {1'b0, sums.even} + {1'b0, sums.odd};
                    half_reg  <= half_m1;
                    hm1_reg   <= h_m1;
                end
            end
            G_MUL:
            begin
                num_reg <= NUM_W'(frame_reg) * NUM_W'(half_reg);
                den_reg <= DEN_W'(fsum_reg) * DEN_W'(hm1_reg);
            end
            G_CHECK:
            begin
                rem_reg <= REM_W'(num_reg) << FRAC_BITS;
                dsh_reg <= REM_W'(den_reg) << (GAMMA_W - 1);
                quo_reg <= overflow ? '1 : '0;
                sat_reg <= overflow;
            end
            G_DIV:
            begin
                if (take)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg <= dsh_reg >> 1;
                quo_reg <= {quo_reg[GAMMA_W-2:0], take};
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_frame_reg <= frame_reg;
            out_even_reg  <= even_reg[FIELD_W-1:0];
            out_odd_reg   <= odd_reg[FIELD_W-1:0];
            out_gamma_reg <= quo_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.frame_ssd       = out_frame_reg;
    assign res.even_field_ssd  = out_even_reg;
    assign res.odd_field_ssd   = out_odd_reg;
    assign res.gamma_q16       = out_gamma_reg;
    assign res.gamma_saturated = out_sat_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == G_IDLE)
        else $error("frame sums arrived while the ratio unit was busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == G_DIV |-> rem_reg < {dsh_reg[REM_W-2:0], 1'b0})
        else $error("divider remainder out of range");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == G_DONE && out_valid_reg && !res.ready |=> state_reg == G_DONE)
        else $error("ratio result left while the result register was full");

endmodule

`default_nettype wire

FILE: rtl/interlace_field_ssd_metric.sv
// ============================================================================
// interlace_field_ssd_metric
// Per-frame sums of squared vertical differences (adjacent rows, and rows two
// apart split by field) and the normalized frame over field ratio gamma.
// ============================================================================
//
//  Port      Dir   Beat contents
//  --------  ----  -----------------------------------------------------------
//  pix       in    one 8-bit luma pixel, raster order
//  res       out   frame/even/odd SSD sums, gamma_q16, gamma_saturated
//  APB       in    line_width at 0x0, frame_height at 0x4
//
//  One pixel per cycle is accepted; each pixel reads its column of the line
//  memory in the cycle of acceptance and accumulates in the next.
//  The last pixel of a frame hands the sums to the ratio unit, which captures
//  them, multiplies, checks, runs 24 divide steps and loads the result.
//  The last pixel of a following frame is held off while that unit is busy;
//  a full result register holds the unit, never the other pixels.
//  The line memory is not cleared after reset; reset clears counters and sums.
//
`default_nettype none

module interlace_field_ssd_metric import ifssd_pkg::*; #(
    parameter int MAX_LINE_WIDTH   = 4096,
    parameter int MAX_FRAME_HEIGHT = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ifssd_pix_if.sink               pix,
    ifssd_res_if.source             res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    localparam int CW   = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W = $clog2(MAX_LINE_WIDTH + 1);
    localparam int RW   = $clog2(MAX_FRAME_HEIGHT);
    localparam int HW   = $clog2(MAX_FRAME_HEIGHT + 1);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic [CFG_W:0]   w_wide;
    logic [CFG_W:0]   h_wide;
    logic [LW_W-1:0]  w_eff;
    logic [HW-1:0]    h_eff;

    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             col_last;
    logic             row_last;
    logic             head_last;
    logic             accept;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_ge1_reg;
    logic             s1_ge2_reg;
    logic             s1_odd_reg;

    logic [LS_DW-1:0] ls_rd;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] d2;
    logic [SQ_W-1:0]  sq1;
    logic [SQ_W-1:0]  sq2;

    logic [ACC_W-1:0] frame_acc_reg, frame_acc_next;
    logic [ACC_W-1:0] even_acc_reg, even_acc_next;
    logic [ACC_W-1:0] odd_acc_reg, odd_acc_next;

    frame_sums_t      sums;
    logic             gamma_start;
    logic             gamma_busy;
    logic [HW-2:0]    half_m1;
    logic [HW-1:0]    h_m1;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= LINE_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_LINE_WIDTH:   width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_LINE_WIDTH:   prdata = APB_DW'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Width clamps to 1..max; height clamps to 4..max and is forced even.
    always_comb
    begin
        w_wide = {1'b0, width_reg};
        if (w_wide == '0)
        begin
            w_wide = (CFG_W + 1)'(1);
        end
        else if (w_wide > (CFG_W + 1)'(MAX_LINE_WIDTH))
        begin
            w_wide = (CFG_W + 1)'(MAX_LINE_WIDTH);
        end

        h_wide = {1'b0, height_reg};
        if (h_wide < (CFG_W + 1)'(MIN_FRAME_HEIGHT))
        begin
            h_wide = (CFG_W + 1)'(MIN_FRAME_HEIGHT);
        end
        else if (h_wide > (CFG_W + 1)'(MAX_FRAME_HEIGHT))
        begin
            h_wide = (CFG_W + 1)'(MAX_FRAME_HEIGHT);
        end
        h_wide[0] = 1'b0;
    end

    assign w_eff   = w_wide[LW_W-1:0];
    assign h_eff   = h_wide[HW-1:0];
    assign half_m1 = h_eff[HW-1:1] - 1'b1;
    assign h_m1    = h_eff - 1'b1;

    // ------------------------------------------------------------------
    // Raster position and input acceptance
    // ------------------------------------------------------------------
    assign col_last  = (LW_W'(col_reg) + 1'b1) == w_eff;
    assign row_last  = (HW'(row_reg) + 1'b1) == h_eff;
    assign head_last = col_last && row_last;

    // Only a frame-ending pixel has to wait for the ratio unit.
    assign pix.ready = !(head_last && (gamma_busy || (s1_valid_reg && s1_last_reg)));
    assign accept    = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_wr)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix.pixel;
            s1_col_reg  <= col_reg;
            s1_last_reg <= head_last;
            s1_ge1_reg  <= row_reg != '0;
            s1_ge2_reg  <= row_reg[RW-1:1] != '0;
            s1_odd_reg  <= row_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Line memory: word holds {row above, two rows above} of a column.
    // ------------------------------------------------------------------
    ifssd_line_store #(
        .DEPTH (MAX_LINE_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ls_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_pix_reg, up1})
    );

    assign up1 = ls_rd[LS_DW-1:PIX_W];
    assign up2 = ls_rd[PIX_W-1:0];
    assign d1  = (up1 > s1_pix_reg) ? up1 - s1_pix_reg : s1_pix_reg - up1;
    assign d2  = (up2 > s1_pix_reg) ? up2 - s1_pix_reg : s1_pix_reg - up2;
    assign sq1 = SQ_W'(d1) * SQ_W'(d1);
    assign sq2 = SQ_W'(d2) * SQ_W'(d2);

    // ------------------------------------------------------------------
    // Accumulation
    // ------------------------------------------------------------------
    always_comb
    begin
        frame_acc_next = frame_acc_reg + (s1_ge1_reg ? ACC_W'(sq1) : '0);
        even_acc_next  = even_acc_reg
                         + ((s1_ge2_reg && !s1_odd_reg) ? ACC_W'(sq2) : '0);
        odd_acc_next   = odd_acc_reg
                         + ((s1_ge2_reg && s1_odd_reg) ? ACC_W'(sq2) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_acc_reg <= '0;
            even_acc_reg  <= '0;
            odd_acc_reg   <= '0;
        end
        else if (cfg_wr || (s1_valid_reg && s1_last_reg))
        begin
            frame_acc_reg <= '0;
            even_acc_reg  <= '0;
            odd_acc_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            frame_acc_reg <= frame_acc_next;
            even_acc_reg  <= even_acc_next;
            odd_acc_reg   <= odd_acc_next;
        end
    end

    assign gamma_start = s1_valid_reg && s1_last_reg;
    assign sums.frame  = frame_acc_next;
    assign sums.even   = even_acc_next;
    assign sums.odd    = odd_acc_next;

    ifssd_gamma #(
        .HW (HW)
    ) u_gamma (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (gamma_start),
        .sums    (sums),
        .half_m1 (half_m1),
        .h_m1    (h_m1),
        .busy    (gamma_busy),
        .res     (res)
    );

    a_last_finds_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> !gamma_busy)
        else $error("frame end reached a busy ratio unit");

    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        LW_W'(col_reg) < w_eff)
        else $error("column position beyond the line width");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |=>
            frame_acc_reg == '0 && even_acc_reg == '0 && odd_acc_reg == '0)
        else $error("sums not cleared after the frame end");

endmodule

`default_nettype wire
